### hw/rtl/sm3he_pkg.sv
// SM3 hash engine package: item types, round register type, constants and
// the rotate and permutation helpers. No dependencies.
package sm3he_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  valid_bytes;
        logic        end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_done;
    } t_out_item;

    // round registers A..H, index 0 is A
    typedef logic [7:0][31:0] t_regs;

    // expansion window taps relative to round j
    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w3;
        logic [31:0] w4;
        logic [31:0] w7;
        logic [31:0] w10;
        logic [31:0] w13;
    } t_taps;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_OUT
    } t_state;

    localparam logic [31:0] TJ_LOW   = 32'h79CC4519;
    localparam logic [31:0] TJ_HIGH  = 32'h7A879D8A;
    localparam logic [31:0] PAD_WORD = 32'h80000000;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam t_regs SM3_IV = {
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

### hw/rtl/sm3_hash_engine_unit.sv
// SM3 hash engine top level: word gathering, padding, round sequencer and
// digest output. Depends on sm3he_pkg and sm3he_round.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------
//  in      | to block  | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  out     | from block| o_out_valid / i_out_stall  | o_out_data (t_out_item)
//
// A word that does not fill a block is taken while idle. The sixteenth word of
// a block starts the compression, one round a cycle through the single shared
// round unit; input is stalled until the compression of the block is over.
// The final word adds one padding word per remaining word slot (one or two
// blocks), the compression of each padded block, then the eight digest words.
// Reset loads the SM3 initial value and clears all counters; no clearing pass.
// Input is stalled whenever the block is not idle; a stalled output item holds.
module sm3_hash_engine_unit import sm3he_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_state          r_state, n_state;
    logic [15:0][31:0] r_win;       // block words, then expansion window
    t_regs           r_regs;        // A..H
    t_regs           r_cv;          // chaining value
    logic [3:0]      r_wc;          // words held in current block
    logic [54:0]     r_blocks;
    logic [63:0]     r_len;
    logic [5:0]      r_rnd;
    logic [2:0]      r_oidx;
    logic            r_inpad;       // padding of this message under way
    logic            r_padpend;     // standalone pad word still to place
    logic            r_lenok;       // length fits in this block
    logic            r_lastblk;     // block being compressed is the last one

    logic            accept, shift_en, go_comp;
    logic [31:0]     shift_w, final_w, wn;
    logic [2:0]      nv;
    logic [6:0]      msg_bytes;
    t_regs           round_out;
    t_taps           taps;

    assign accept = i_in_valid && !o_in_stall;

    // saturate the byte count; below four only counts on the final word
    assign nv = (!i_in_data.end_of_message || i_in_data.valid_bytes > 3'd4) ?
                3'd4 : i_in_data.valid_bytes;
    assign msg_bytes = {1'b0, r_wc, 2'b00} + {4'd0, nv};

    // keep the valid leading bytes and, on a short final word, append the pad byte after them
    always_comb begin
        case (nv)
            3'd0:    final_w = PAD_WORD;
            3'd1:    final_w = {i_in_data.message_word[31:24], PAD_BYTE, 16'd0};
            3'd2:    final_w = {i_in_data.message_word[31:16], PAD_BYTE, 8'd0};
            3'd3:    final_w = {i_in_data.message_word[31:8], PAD_BYTE};
            default: final_w = i_in_data.message_word;
        endcase
    end

    assign taps = '{w0: r_win[0], w3: r_win[3], w4: r_win[4], w7: r_win[7],
                    w10: r_win[10], w13: r_win[13]};

    sm3he_round u_round (
        .i_rnd  (r_rnd),
        .i_regs (r_regs),
        .i_taps (taps),
        .o_regs (round_out),
        .o_wn   (wn)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && r_wc == 4'd15 && nv == 3'd4)
                    n_state = ST_COMP;
                else if (accept && r_wc == 4'd15)
                    n_state = ST_COMP;
                else if (accept && i_in_data.end_of_message)
                    n_state = ST_PAD;
            end
            ST_PAD: begin
                if (r_wc == 4'd15)
                    n_state = ST_COMP;
            end
            ST_COMP: begin
                if (r_rnd == 6'd63)
                    n_state = r_lastblk ? ST_OUT : (r_inpad ? ST_PAD : ST_IDLE);
            end
            ST_OUT: begin
                if (!i_out_stall && r_oidx == 3'd7)
                    n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and block word source
    always_comb begin
        shift_en    = 1'b0;
        shift_w     = 32'd0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                shift_en   = accept;
                shift_w    = final_w;
            end
            ST_PAD: begin
                shift_en = 1'b1;
                if (r_padpend)
                    shift_w = PAD_WORD;
                else if (r_wc == 4'd14 && r_lenok)
                    shift_w = r_len[63:32];
                else if (r_wc == 4'd15 && r_lenok)
                    shift_w = r_len[31:0];
                else
                    shift_w = 32'd0;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                shift_en = 1'b0;
            end
        endcase
    end

    assign go_comp = shift_en && (r_wc == 4'd15);

    assign o_out_data = '{digest_word: r_cv[r_oidx], word_index: r_oidx,
                          digest_done: (r_oidx == 3'd7)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cv      <= SM3_IV;
            r_wc      <= 4'd0;
            r_blocks  <= 55'd0;
            r_rnd     <= 6'd0;
            r_oidx    <= 3'd0;
            r_inpad   <= 1'b0;
            r_padpend <= 1'b0;
            r_lenok   <= 1'b0;
            r_lastblk <= 1'b0;
        end else begin
            r_state <= n_state;
            // shift the next block word in at the top
            if (shift_en) begin
                r_win <= {shift_w, r_win[15:1]};
                r_wc  <= r_wc + 4'd1;
            end
            if (go_comp) begin
                r_regs <= r_cv;
                r_rnd  <= 6'd0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (go_comp)
                        r_blocks <= r_blocks + 55'd1;
                    if (accept && i_in_data.end_of_message) begin
                        r_len     <= {r_blocks, 9'd0} + {54'd0, msg_bytes, 3'd0};
                        r_inpad   <= 1'b1;
                        r_padpend <= (nv == 3'd4);
                        if (nv != 3'd4)
                            r_lenok <= (r_wc < 4'd14);
                    end
                end
                ST_PAD: begin
                    if (r_padpend) begin
                        r_padpend <= 1'b0;
                        r_lenok   <= (r_wc < 4'd14);
                    end else if (r_wc == 4'd15 && r_lenok) begin
                        r_lastblk <= 1'b1;
                    end
                end
                ST_COMP: begin
                    // one round a cycle, window advances by one word
                    r_regs <= round_out;
                    r_win  <= {wn, r_win[15:1]};
                    r_rnd  <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) begin
                        r_cv    <= r_cv ^ round_out;
                        r_lenok <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (!i_out_stall) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_cv      <= SM3_IV;
                            r_blocks  <= 55'd0;
                            r_wc      <= 4'd0;
                            r_inpad   <= 1'b0;
                            r_lastblk <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_rnd <= 6'd0;
                end
            endcase
        end
    end

endmodule

### hw/rtl/sm3he_round.sv
// SM3 compression round: one round of FF/GG, SS1/SS2, TT1/TT2 and the next
// expanded message word. Depends on sm3he_pkg.
module sm3he_round import sm3he_pkg::*; (
    input  logic [5:0]  i_rnd,
    input  t_regs       i_regs,
    input  t_taps       i_taps,
    output t_regs       o_regs,
    output logic [31:0] o_wn
);

    logic [31:0] a12, tj, ss1, ss2, ff, gg, tt1, tt2;
    logic        early;

    assign early = (i_rnd < 6'd16);
    assign a12   = rotl(i_regs[0], 5'd12);
    assign tj    = early ? TJ_LOW : TJ_HIGH;
    assign ss1   = rotl(a12 + i_regs[4] + rotl(tj, i_rnd[4:0]), 5'd7);
    assign ss2   = ss1 ^ a12;

    always_comb begin
        if (early) begin
            ff = i_regs[0] ^ i_regs[1] ^ i_regs[2];
            gg = i_regs[4] ^ i_regs[5] ^ i_regs[6];
        end else begin
            ff = (i_regs[0] & i_regs[1]) | (i_regs[0] & i_regs[2]) | (i_regs[1] & i_regs[2]);
            gg = (i_regs[4] & i_regs[5]) | (~i_regs[4] & i_regs[6]);
        end
    end

    assign tt1 = ff + i_regs[3] + ss2 + (i_taps.w0 ^ i_taps.w4);
    assign tt2 = gg + i_regs[7] + ss1 + i_taps.w0;

    always_comb begin
        o_regs[0] = tt1;
        o_regs[1] = i_regs[0];
        o_regs[2] = rotl(i_regs[1], 5'd9);
        o_regs[3] = i_regs[2];
        o_regs[4] = perm0(tt2);
        o_regs[5] = i_regs[4];
        o_regs[6] = rotl(i_regs[5], 5'd19);
        o_regs[7] = i_regs[6];
    end

    assign o_wn = perm1(i_taps.w0 ^ i_taps.w7 ^ rotl(i_taps.w13, 5'd15))
                  ^ rotl(i_taps.w3, 5'd7) ^ i_taps.w10;

endmodule
